// ----- rtl/core/kdj_pkg.sv -----
// ----------------------------------------------------------------------------
// kdj_pkg
// Shared widths, constants, types and helper function of the KDJ oscillator.
// ----------------------------------------------------------------------------
package kdj_pkg;

    localparam int WINDOW_MAX = 16;
    localparam int PRICE_BITS = 32;
    localparam int FRAC_BITS  = 16;

    localparam int CFG_BITS   = 5;
    localparam int LEN_BITS   = $clog2(WINDOW_MAX + 1);
    localparam int SCALE_BITS = 7;
    localparam int KD_BITS    = FRAC_BITS + SCALE_BITS;
    localparam int J_BITS     = FRAC_BITS + 10;
    localparam int SUM_BITS   = KD_BITS + 2;
    localparam int PROD_BITS  = PRICE_BITS + SCALE_BITS;
    localparam int QCNT_BITS  = $clog2(KD_BITS);

    localparam logic [CFG_BITS-1:0]   WINLEN_RESET = CFG_BITS'(9);
    localparam logic [SCALE_BITS-1:0] HUNDRED      = SCALE_BITS'(100);
    localparam logic [KD_BITS-1:0]    FIFTY_FX     = KD_BITS'(50) << FRAC_BITS;
    localparam logic [KD_BITS-1:0]    HUNDRED_FX   = KD_BITS'(100) << FRAC_BITS;

    localparam int DIV3_SHIFT = SUM_BITS + 1;
    localparam longint unsigned DIV3_MULT_WIDE = ((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;
    localparam logic [SUM_BITS-1:0] DIV3_MULT = SUM_BITS'(DIV3_MULT_WIDE);

    typedef logic [PRICE_BITS-1:0] price_t;
    typedef logic [KD_BITS-1:0]    kd_t;
    typedef logic [LEN_BITS-1:0]   len_t;
    typedef logic [SUM_BITS-1:0]   sum_t;

    typedef struct packed {
        logic shift;
        len_t len;
    } win_ctrl_t;

    // Exact floor division by three for any value below 2**SUM_BITS.
    function automatic kd_t div3(input sum_t x);
        logic [2*SUM_BITS-1:0] p;
        p = {{SUM_BITS{1'b0}}, x} * {{SUM_BITS{1'b0}}, DIV3_MULT};
        return KD_BITS'(p >> DIV3_SHIFT);
    endfunction

endpackage

// ----- rtl/core/kdj_stochastic_oscillator.sv -----
// ----------------------------------------------------------------------------
// kdj_stochastic_oscillator
// KDJ stochastic oscillator over a sliding window of price bars.
// ----------------------------------------------------------------------------
// The block takes one bar at a time and returns one result item per bar. A bar
// whose window is not yet full has its result loaded from the output state; a
// full window passes the scan and decide steps, the division when RSV is not
// clamped or flat, and the K and D steps. The next bar is taken once the block
// is idle again after the result is loaded. Time per bar is set by the
// scan down the row of 16 window cells (one cell per cycle) and by the serial
// divider (one quotient bit per cycle). The result sits in an output register,
// so the next bar is taken while the previous result waits. The window length
// register is written through the cfg port and should only be changed while
// the block is idle.
// ----------------------------------------------------------------------------
module kdj_stochastic_oscillator
    import kdj_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_BITS-1:0]      cfg_data,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_series_start,
    input  logic [PRICE_BITS-1:0]    s_high_price,
    input  logic [PRICE_BITS-1:0]    s_low_price,
    input  logic [PRICE_BITS-1:0]    s_close_price,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_valid_res,
    output logic [KD_BITS-1:0]       m_k_value,
    output logic [KD_BITS-1:0]       m_d_value,
    output logic signed [J_BITS-1:0] m_j_value,
    output logic                     m_flat_range
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_DIV,
        ST_K_SUM,
        ST_K_MUL,
        ST_D_SUM,
        ST_D_MUL,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [CFG_BITS-1:0]    winlen_reg;
    len_t                   bars_reg;
    len_t                   scan_cnt_reg;
    kd_t                    k_reg;
    kd_t                    d_reg;
    logic                   full_reg;
    logic                   flat_reg;
    price_t                 close_reg;
    kd_t                    rsv_reg;
    sum_t                   sum_reg;
    logic                   div_start_reg;
    price_t                 div_num_reg;
    price_t                 div_den_reg;

    logic                   m_valid_reg;
    logic                   m_valid_res_reg;
    kd_t                    m_k_reg;
    kd_t                    m_d_reg;
    logic [J_BITS-1:0]      m_j_reg;
    logic                   m_flat_reg;

    len_t                   len_eff;
    len_t                   bars_next;
    logic                   accept;
    logic                   out_free;
    win_ctrl_t              win_ctrl;
    price_t                 win_hi;
    price_t                 win_lo;
    logic                   div_done;
    kd_t                    div_quot;
    logic [J_BITS-1:0]      j_calc;

    always_comb begin
        if (winlen_reg < CFG_BITS'(2)) begin
            len_eff = LEN_BITS'(2);
        end else if (32'(winlen_reg) > WINDOW_MAX) begin
            len_eff = LEN_BITS'(WINDOW_MAX);
        end else begin
            len_eff = LEN_BITS'(winlen_reg);
        end
    end

    always_comb begin
        bars_next = s_series_start ? '0 : bars_reg;
        if (32'(bars_next) < WINDOW_MAX) begin
            bars_next = bars_next + 1'b1;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    assign win_ctrl.shift = accept;
    assign win_ctrl.len   = len_eff;

    kdj_window u_window (
        .aclk   (aclk),
        .ctrl   (win_ctrl),
        .bar_hi (s_high_price),
        .bar_lo (s_low_price),
        .win_hi (win_hi),
        .win_lo (win_lo)
    );

    kdj_rsv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (div_num_reg),
        .den     (div_den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign j_calc = (J_BITS'(k_reg) << 1) + J_BITS'(k_reg) - (J_BITS'(d_reg) << 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            winlen_reg    <= WINLEN_RESET;
            bars_reg      <= '0;
            scan_cnt_reg  <= '0;
            k_reg         <= FIFTY_FX;
            d_reg         <= FIFTY_FX;
            full_reg      <= 1'b0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                winlen_reg <= cfg_data;
            end
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        bars_reg     <= bars_next;
                        close_reg    <= s_close_price;
                        full_reg     <= (bars_next >= len_eff);
                        flat_reg     <= 1'b0;
                        scan_cnt_reg <= '0;
                        if (s_series_start) begin
                            k_reg <= FIFTY_FX;
                            d_reg <= FIFTY_FX;
                        end
                        state_reg <= (bars_next >= len_eff) ? ST_SCAN : ST_OUT;
                    end
                end
                ST_SCAN: begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (scan_cnt_reg == LEN_BITS'(WINDOW_MAX - 1)) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (win_hi <= win_lo) begin
                        flat_reg  <= 1'b1;
                        rsv_reg   <= FIFTY_FX;
                        state_reg <= ST_K_SUM;
                    end else if (close_reg <= win_lo) begin
                        rsv_reg   <= '0;
                        state_reg <= ST_K_SUM;
                    end else if (close_reg >= win_hi) begin
                        rsv_reg   <= HUNDRED_FX;
                        state_reg <= ST_K_SUM;
                    end else begin
                        div_num_reg   <= close_reg - win_lo;
                        div_den_reg   <= win_hi - win_lo;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        rsv_reg   <= div_quot;
                        state_reg <= ST_K_SUM;
                    end
                end
                ST_K_SUM: begin
                    sum_reg   <= (SUM_BITS'(k_reg) << 1) + SUM_BITS'(rsv_reg);
                    state_reg <= ST_K_MUL;
                end
                ST_K_MUL: begin
                    k_reg     <= div3(sum_reg);
                    state_reg <= ST_D_SUM;
                end
                ST_D_SUM: begin
                    sum_reg   <= (SUM_BITS'(d_reg) << 1) + SUM_BITS'(k_reg);
                    state_reg <= ST_D_MUL;
                end
                ST_D_MUL: begin
                    d_reg     <= div3(sum_reg);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_valid_res_reg <= full_reg;
                        m_k_reg         <= full_reg ? k_reg : '0;
                        m_d_reg         <= full_reg ? d_reg : '0;
                        m_j_reg         <= full_reg ? j_calc : '0;
                        m_flat_reg      <= full_reg && flat_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_valid_res  = m_valid_res_reg;
    assign m_k_value    = m_k_reg;
    assign m_d_value    = m_d_reg;
    assign m_j_value    = $signed(m_j_reg);
    assign m_flat_range = m_flat_reg;

    // Only one bar is in flight at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a bar is in flight");

    // A result from a window that is not yet full carries zero fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_k_value == '0 && m_d_value == '0
                                    && m_j_value == '0 && !m_flat_range)
        else $error("nonzero fields on a result from a partial window");

    // K and D stay within 0 to 100.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_k_value <= HUNDRED_FX && m_d_value <= HUNDRED_FX)
        else $error("K or D out of range");

    // The divider is only started from the decision step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> state_reg == ST_DIV)
        else $error("divider started outside the division step");

endmodule

// ----- rtl/core/kdj_cell.sv -----
// ----------------------------------------------------------------------------
// kdj_cell
// One window entry: holds a bar's high and low, shifts them on to the next
// cell, and folds them into the running maximum and minimum that moves down
// the row one cell per cycle.
// ----------------------------------------------------------------------------
module kdj_cell
    import kdj_pkg::*;
(
    input  logic   aclk,
    input  logic   shift_en,
    input  logic   in_win,
    input  price_t din_hi,
    input  price_t din_lo,
    output price_t dout_hi,
    output price_t dout_lo,
    input  price_t scan_in_hi,
    input  price_t scan_in_lo,
    output price_t scan_out_hi,
    output price_t scan_out_lo
);

    price_t hi_reg;
    price_t lo_reg;
    price_t scan_hi_reg;
    price_t scan_lo_reg;
    price_t scan_hi_next;
    price_t scan_lo_next;

    always_comb begin
        scan_hi_next = scan_in_hi;
        scan_lo_next = scan_in_lo;
        if (in_win) begin
            if (hi_reg > scan_in_hi) begin
                scan_hi_next = hi_reg;
            end
            if (lo_reg < scan_in_lo) begin
                scan_lo_next = lo_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            hi_reg <= din_hi;
            lo_reg <= din_lo;
        end
        scan_hi_reg <= scan_hi_next;
        scan_lo_reg <= scan_lo_next;
    end

    assign dout_hi     = hi_reg;
    assign dout_lo     = lo_reg;
    assign scan_out_hi = scan_hi_reg;
    assign scan_out_lo = scan_lo_reg;

endmodule

// ----- rtl/core/kdj_window.sv -----
// ----------------------------------------------------------------------------
// kdj_window
// Row of window cells. The newest bar enters the first cell; the highest
// high and lowest low of the active cells leave the last cell.
// ----------------------------------------------------------------------------
module kdj_window
    import kdj_pkg::*;
(
    input  logic      aclk,
    input  win_ctrl_t ctrl,
    input  price_t    bar_hi,
    input  price_t    bar_lo,
    output price_t    win_hi,
    output price_t    win_lo
);

    price_t ent_hi  [WINDOW_MAX+1];
    price_t ent_lo  [WINDOW_MAX+1];
    price_t scan_hi [WINDOW_MAX+1];
    price_t scan_lo [WINDOW_MAX+1];

    assign ent_hi[0]  = bar_hi;
    assign ent_lo[0]  = bar_lo;
    assign scan_hi[0] = '0;
    assign scan_lo[0] = '1;

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        kdj_cell u_cell (
            .aclk        (aclk),
            .shift_en    (ctrl.shift),
            .in_win      (LEN_BITS'(i) < ctrl.len),
            .din_hi      (ent_hi[i]),
            .din_lo      (ent_lo[i]),
            .dout_hi     (ent_hi[i+1]),
            .dout_lo     (ent_lo[i+1]),
            .scan_in_hi  (scan_hi[i]),
            .scan_in_lo  (scan_lo[i]),
            .scan_out_hi (scan_hi[i+1]),
            .scan_out_lo (scan_lo[i+1])
        );
    end

    assign win_hi = scan_hi[WINDOW_MAX];
    assign win_lo = scan_lo[WINDOW_MAX];

endmodule

// ----- rtl/core/kdj_rsv_div.sv -----
// ----------------------------------------------------------------------------
// kdj_rsv_div
// Serial restoring divider for RSV: floor(num * 100 * 2**FRAC_BITS / den)
// with num below den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kdj_rsv_div
    import kdj_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   start,
    input  price_t num,
    input  price_t den,
    output logic   done,
    output kd_t    quot
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN
    } div_state_t;

    div_state_t               state_reg;
    logic                     done_reg;
    logic [QCNT_BITS-1:0]     cnt_reg;
    logic [PROD_BITS-1:0]     prod_reg;
    price_t                   den_reg;
    price_t                   rem_reg;
    kd_t                      sh_reg;
    logic [PRICE_BITS:0]      trial;
    logic                     qbit;

    assign trial = {rem_reg, sh_reg[KD_BITS-1]};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        prod_reg  <= PROD_BITS'(num) * PROD_BITS'(HUNDRED);
                        den_reg   <= den;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    rem_reg   <= prod_reg[PROD_BITS-1:SCALE_BITS];
                    sh_reg    <= {prod_reg[SCALE_BITS-1:0], FRAC_BITS'(0)};
                    cnt_reg   <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    rem_reg <= qbit ? PRICE_BITS'(trial - {1'b0, den_reg})
                                    : PRICE_BITS'(trial);
                    sh_reg  <= {sh_reg[KD_BITS-2:0], qbit};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == QCNT_BITS'(KD_BITS - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

// ----- dv/kdj_stochastic_oscillator_checker.sv -----
// ----------------------------------------------------------------------------
// kdj_stochastic_oscillator_checker
// Watches the bar, result and window length channels of the KDJ oscillator,
// predicts the K, D and J lines of every accepted bar and compares each
// accepted result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module kdj_stochastic_oscillator_checker
    import kdj_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_BITS-1:0]      cfg_data,

    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_series_start,
    input  logic [PRICE_BITS-1:0]    s_high_price,
    input  logic [PRICE_BITS-1:0]    s_low_price,
    input  logic [PRICE_BITS-1:0]    s_close_price,

    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic                     m_valid_res,
    input  logic [KD_BITS-1:0]       m_k_value,
    input  logic [KD_BITS-1:0]       m_d_value,
    input  logic signed [J_BITS-1:0] m_j_value,
    input  logic                     m_flat_range,

    output int                       outstanding,
    output int                       fail_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                     valid_res;
        kd_t                      k_value;
        kd_t                      d_value;
        logic signed [J_BITS-1:0] j_value;
        logic                     flat_range;
    } kdj_result_t;

    price_t               high_hist [WINDOW_MAX];
    price_t               low_hist [WINDOW_MAX];
    int                   bars_held;
    kd_t                  k_line;
    kd_t                  d_line;
    logic [CFG_BITS-1:0]  win_len;
    kdj_result_t          kdj_expected_q[$];
    kdj_result_t          want;
    int                   mismatches = 0;

    function automatic kdj_result_t take_bar(input logic restart, input price_t hi_in,
                                             input price_t lo_in, input price_t cl);
        kdj_result_t r;
        int          len;
        int          i;
        price_t      hi;
        price_t      lo;
        logic [63:0] rsv;
        longint      kl;
        longint      dl;
        longint      j_wide;
        r = '0;
        if (restart) begin
            bars_held = 0;
            k_line = FIFTY_FX;
            d_line = FIFTY_FX;
        end
        for (i = WINDOW_MAX - 1; i > 0; i--) begin
            high_hist[i] = high_hist[i-1];
            low_hist[i] = low_hist[i-1];
        end
        high_hist[0] = hi_in;
        low_hist[0] = lo_in;
        if (bars_held < WINDOW_MAX) begin
            bars_held++;
        end
        len = int'(win_len);
        if (len < 2) begin
            len = 2;
        end
        if (len > WINDOW_MAX) begin
            len = WINDOW_MAX;
        end
        if (bars_held < len) begin
            return r;
        end
        hi = high_hist[0];
        lo = low_hist[0];
        for (i = 1; i < len; i++) begin
            if (high_hist[i] > hi) begin
                hi = high_hist[i];
            end
            if (low_hist[i] < lo) begin
                lo = low_hist[i];
            end
        end
        if (hi <= lo) begin
            r.flat_range = 1'b1;
            rsv = 64'(FIFTY_FX);
        end else if (cl <= lo) begin
            rsv = '0;
        end else if (cl >= hi) begin
            rsv = 64'(HUNDRED_FX);
        end else begin
            rsv = ((64'(cl - lo) * 100) << FRAC_BITS) / 64'(hi - lo);
        end
        k_line = kd_t'((2 * 64'(k_line) + rsv) / 3);
        d_line = kd_t'((2 * 64'(d_line) + 64'(k_line)) / 3);
        kl = longint'(k_line);
        dl = longint'(d_line);
        j_wide = 3 * kl - 2 * dl;
        r.valid_res = 1'b1;
        r.k_value = k_line;
        r.d_value = d_line;
        r.j_value = J_BITS'(j_wide);
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want_v,
                               input logic signed [63:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_MAX; i++) begin
                high_hist[i] = '0;
                low_hist[i] = '0;
            end
            bars_held = 0;
            k_line = FIFTY_FX;
            d_line = FIFTY_FX;
            win_len = WINLEN_RESET;
            kdj_expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                win_len = cfg_data;
            end
            if (s_valid && s_ready) begin
                kdj_expected_q.push_back(take_bar(s_series_start, s_high_price,
                                                  s_low_price, s_close_price));
            end
            if (m_valid && m_ready) begin
                if (kdj_expected_q.size() == 0) begin
                    $error("Result item arrived with no bar outstanding.");
                    mismatches++;
                end else begin
                    want = kdj_expected_q.pop_front();
                    check_field("valid_res", want.valid_res, m_valid_res);
                    check_field("k_value", want.k_value, m_k_value);
                    check_field("d_value", want.d_value, m_d_value);
                    check_field("j_value", want.j_value, m_j_value);
                    check_field("flat_range", want.flat_range, m_flat_range);
                end
            end
        end
        outstanding <= kdj_expected_q.size();
        fail_count <= mismatches;
    end

endmodule

// ----- dv/kdj_stochastic_oscillator_tb.sv -----
// ----------------------------------------------------------------------------
// kdj_stochastic_oscillator_tb
// Drives price bars and window length writes into the KDJ oscillator: a short
// directed run over extreme prices, flat and inverted windows and clamped RSV,
// then random price series under several window lengths and idling patterns,
// including a long hold on the result side. The checker gives the verdict.
// ----------------------------------------------------------------------------
module kdj_stochastic_oscillator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kdj_pkg::*;

    localparam int RUN_LIMIT     = 600_000;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_CYCLES  = 200;
    localparam int SEGMENT_BARS  = 88;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_BITS-1:0]      cfg_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_series_start = 1'b0;
    price_t                   s_high_price = '0;
    price_t                   s_low_price = '0;
    price_t                   s_close_price = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_valid_res;
    logic [KD_BITS-1:0]       m_k_value;
    logic [KD_BITS-1:0]       m_d_value;
    logic signed [J_BITS-1:0] m_j_value;
    logic                     m_flat_range;

    int     outstanding;
    int     fail_count;
    int     send_idle_pct = 20;
    int     recv_idle_pct = 73;
    logic   hold_go = 1'b0;
    logic   hold_active = 1'b0;
    longint walk_mid = 0;
    longint walk_step = 1;
    int     series_left = 0;
    int     cycle_count = 0;

    kdj_stochastic_oscillator i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_series_start (s_series_start),
        .s_high_price   (s_high_price),
        .s_low_price    (s_low_price),
        .s_close_price  (s_close_price),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_valid_res    (m_valid_res),
        .m_k_value      (m_k_value),
        .m_d_value      (m_d_value),
        .m_j_value      (m_j_value),
        .m_flat_range   (m_flat_range)
    );

    kdj_stochastic_oscillator_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_series_start (s_series_start),
        .s_high_price   (s_high_price),
        .s_low_price    (s_low_price),
        .s_close_price  (s_close_price),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_valid_res    (m_valid_res),
        .m_k_value      (m_k_value),
        .m_d_value      (m_d_value),
        .m_j_value      (m_j_value),
        .m_flat_range   (m_flat_range),
        .outstanding    (outstanding),
        .fail_count     (fail_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // The result side stops for a long stretch so the block backs up its input.
    initial begin : receiver_hold
        wait (hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active <= 1'b0;
    end

    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic price_t fit_price(input longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > 64'hFFFF_FFFF) begin
            return '1;
        end
        return price_t'(v);
    endfunction

    task automatic send_bar(input logic restart, input price_t hi, input price_t lo,
                            input price_t cl);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_series_start <= restart;
        s_high_price <= hi;
        s_low_price <= lo;
        s_close_price <= cl;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_window_length(input logic [CFG_BITS-1:0] len);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_bars(input int count);
        longint h;
        longint l;
        longint c;
        longint spread;
        logic   restart;
        price_t nh;
        price_t nl;
        price_t nc;
        int     pick;
        repeat (count) begin
            restart = 1'b0;
            if (series_left == 0) begin
                restart = 1'b1;
                series_left = ($urandom_range(9) == 0) ? $urandom_range(1, 6)
                                                       : $urandom_range(12, 48);
                walk_step = longint'($urandom_range(1, 1 << $urandom_range(1, 28)));
                if ($urandom_range(7) == 0) begin
                    walk_step = 0;
                end
                case ($urandom_range(3))
                    0: walk_mid = longint'($urandom);
                    1: walk_mid = longint'($urandom_range(0, 3000));
                    2: walk_mid = 64'hFFFF_FFFF - longint'($urandom_range(0, 3000));
                    default: walk_mid = longint'($urandom_range(1000, 100000));
                endcase
            end else if ($urandom_range(199) == 0) begin
                restart = 1'b1;
            end
            series_left--;
            pick = $urandom_range(99);
            if (pick < 88) begin
                walk_mid = walk_mid + longint'($urandom_range(0, 2 * walk_step)) - walk_step;
                walk_mid = longint'(fit_price(walk_mid));
                spread = longint'($urandom_range(0, walk_step));
                h = walk_mid + longint'($urandom_range(0, spread));
                l = walk_mid - longint'($urandom_range(0, spread));
                c = l - spread / 4 + longint'($urandom_range(0, h - l + spread / 2));
                nh = fit_price(h);
                nl = fit_price(l);
                nc = fit_price(c);
            end else if (pick < 93) begin
                nh = $urandom;
                nl = $urandom;
                nc = $urandom;
            end else if (pick < 97) begin
                nh = fit_price(walk_mid);
                nl = nh;
                nc = $urandom_range(1) ? nh : price_t'($urandom);
            end else begin
                nh = fit_price(walk_mid - walk_step);
                nl = fit_price(walk_mid + walk_step);
                nc = fit_price(walk_mid);
            end
            send_bar(restart, nh, nl, nc);
        end
    endtask

    initial begin : stimulus
        logic [CFG_BITS-1:0] len_plan [12];
        int                  plan_idx;
        int                  i;
        len_plan = '{5'd16, 5'd0, 5'd31, 5'd2, 5'd1, 5'd17,
                     5'd9, 5'd5, 5'd3, 5'd12, 5'd7, 5'd14};
        plan_idx = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset window length: the full price range sits in the window first.
        send_bar(1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
        for (i = 0; i < 9; i++) begin
            send_bar(1'b0, price_t'(5000 + i * 97), price_t'(4000 - i * 53),
                     price_t'(4500 + i * 31));
        end

        write_window_length(5'd2);
        send_bar(1'b1, 32'd100, 32'd100, 32'd100);
        send_bar(1'b0, 32'd100, 32'd100, 32'd100);
        send_bar(1'b0, 32'd50, 32'd200, 32'd70);
        send_bar(1'b0, 32'd40, 32'd300, 32'd0);
        send_bar(1'b0, 32'd1000, 32'd900, 32'd800);
        send_bar(1'b0, 32'd1000, 32'd500, 32'd200);
        send_bar(1'b0, 32'd2000, 32'd600, 32'd2000);
        send_bar(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFE);
        send_bar(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
        send_bar(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bar(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        send_bar(1'b1, 32'd5, 32'd3, 32'd4);
        send_bar(1'b0, 32'd7, 32'd1, 32'd2);

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct <= 20;
                    recv_idle_pct <= 73;
                end
                1: begin
                    send_idle_pct <= 73;
                    recv_idle_pct <= 20;
                end
                default: begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                write_window_length(len_plan[plan_idx]);
                plan_idx++;
                if (mode == 2 && seg == 0) begin
                    hold_go <= 1'b1;
                end
                series_left = 0;
                send_random_bars(SEGMENT_BARS);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
